// ===== src/co2rc_pkg.sv =====
// ----------------------------------------------------------------------------
// CO2 reply checker package
// Item types, configuration type and code constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package co2rc_pkg;

  localparam int unsigned FrameLen = 9;

  localparam logic [7:0] HEADER_START = 8'hFF;
  localparam logic [7:0] HEADER_CMD   = 8'h86;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_STALE     = 3'd1;
  localparam logic [2:0] ST_STUCK     = 3'd2;
  localparam logic [2:0] ST_NO_REPLY  = 3'd3;
  localparam logic [2:0] ST_BAD_FRAME = 3'd4;
  localparam logic [2:0] ST_BAD_SUM   = 3'd5;
  localparam logic [2:0] ST_ZERO      = 3'd6;

  localparam logic REG_STALE_REPEAT_CYCLES = 1'b0;
  localparam logic REG_SUSPICIOUS_LEVEL    = 1'b1;

  localparam logic [7:0]  STALE_RESET      = 8'd3;
  localparam logic [15:0] SUSPICIOUS_RESET = 16'd5000;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ppm;
    logic [7:0]  repeat_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  stale_repeat_cycles;
    logic [15:0] suspicious_level;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/co2_sensor_reply_checker.sv =====
// Checks the 9-byte reply frame of a UART CO2 sensor, one received byte per
// item, and reports one result per closed frame (reading, header or checksum
// fault, zero reading) or per timeout. An item is taken in every cycle unless the
// input stalls; it is registered on entry, then decoded against the frame state
// and any result is written to the result register once the held result, if any,
// has been taken. The input side stalls only while a held result waits to be
// taken and the item in the entry register must move on.
// ----------------------------------------------------------------------------
// CO2 sensor reply checker top level
// Entry register, configuration registers, frame tracker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_reply_checker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire co2rc_pkg::in_item_t   in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output co2rc_pkg::out_item_t       out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_data
);

  co2rc_pkg::cfg_t      cfg;
  co2rc_pkg::in_item_t  entry;
  logic                 entry_valid;
  logic                 blocked;
  logic                 step;
  logic                 result_valid;
  co2rc_pkg::out_item_t result;

  assign cfg_ready = 1'b1;
  assign step      = entry_valid && !blocked;
  assign in_stall  = entry_valid && blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_repeat_cycles <= co2rc_pkg::STALE_RESET;
      cfg.suspicious_level    <= co2rc_pkg::SUSPICIOUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == co2rc_pkg::REG_STALE_REPEAT_CYCLES) begin
        cfg.stale_repeat_cycles <= cfg_data[7:0];
      end
      if (cfg_index == co2rc_pkg::REG_SUSPICIOUS_LEVEL) begin
        cfg.suspicious_level <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (!in_stall) begin
      entry_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      entry <= in_item;
    end
  end

  co2rc_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (entry),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  co2rc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && result_valid),
    .load_item (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .blocked   (blocked)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && entry_valid)
    else $error("input stalled without a held result");

  a_ppm_zero_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == co2rc_pkg::ST_NO_REPLY ||
                  out_item.status == co2rc_pkg::ST_BAD_FRAME ||
                  out_item.status == co2rc_pkg::ST_BAD_SUM ||
                  out_item.status == co2rc_pkg::ST_ZERO) |-> out_item.ppm == 16'd0)
    else $error("fault result carries a concentration");

  a_reading_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == co2rc_pkg::ST_OK ||
                  out_item.status == co2rc_pkg::ST_STALE ||
                  out_item.status == co2rc_pkg::ST_STUCK) |-> out_item.ppm != 16'd0)
    else $error("reading result with zero concentration");

endmodule

`default_nettype wire

// ===== src/co2rc_frame.sv =====
// ----------------------------------------------------------------------------
// CO2 reply checker frame tracker
// Holds the frame and streak state and decodes one item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module co2rc_frame (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire co2rc_pkg::in_item_t  item,
  input  wire co2rc_pkg::cfg_t      cfg,
  output logic                      result_valid,
  output co2rc_pkg::out_item_t      result
);

  localparam logic [3:0] LastPos = 4'(co2rc_pkg::FrameLen - 1);
  localparam logic [3:0] FullPos = 4'(co2rc_pkg::FrameLen);

  logic [3:0]  bytes_received, bytes_received_next;
  logic        header_good, header_good_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  level_high_byte, level_high_byte_next;
  logic [7:0]  level_low_byte, level_low_byte_next;
  logic [15:0] previous_level, previous_level_next;
  logic [7:0]  same_streak, same_streak_next;

  logic        closed;
  logic [7:0]  expected;
  logic [15:0] level;
  logic        stale;

  assign closed   = bytes_received >= FullPos;
  assign expected = 8'(8'd0 - running_sum);
  assign level    = {level_high_byte, level_low_byte};

  always_comb begin
    bytes_received_next  = bytes_received;
    header_good_next     = header_good;
    running_sum_next     = running_sum;
    level_high_byte_next = level_high_byte;
    level_low_byte_next  = level_low_byte;
    previous_level_next  = previous_level;
    same_streak_next     = same_streak;
    result_valid         = 1'b0;
    result.status        = co2rc_pkg::ST_OK;
    result.ppm           = 16'd0;
    stale                = 1'b0;

    case (item.action)
      co2rc_pkg::ACT_START: begin
        bytes_received_next  = 4'd0;
        header_good_next     = 1'b1;
        running_sum_next     = 8'd0;
        level_high_byte_next = 8'd0;
        level_low_byte_next  = 8'd0;
      end
      co2rc_pkg::ACT_TIMEOUT: begin
        if (!closed) begin
          bytes_received_next = FullPos;
          result_valid        = 1'b1;
          result.status       = co2rc_pkg::ST_NO_REPLY;
        end
      end
      co2rc_pkg::ACT_BYTE: begin
        if (!closed) begin
          if (bytes_received == LastPos) begin
            bytes_received_next = FullPos;
            result_valid        = 1'b1;
            if (!header_good) begin
              result.status = co2rc_pkg::ST_BAD_FRAME;
            end else if (expected != item.rx_byte) begin
              result.status = co2rc_pkg::ST_BAD_SUM;
            end else if (level == 16'd0) begin
              result.status = co2rc_pkg::ST_ZERO;
            end else begin
              if (level == previous_level) begin
                if (same_streak != 8'hFF) begin
                  same_streak_next = same_streak + 8'd1;
                end
              end else begin
                same_streak_next = 8'd0;
              end
              previous_level_next = level;
              stale = ({1'b0, same_streak_next} + 9'd1) >= {1'b0, cfg.stale_repeat_cycles};
              result.ppm = level;
              if (stale) begin
                result.status = (level >= cfg.suspicious_level) ? co2rc_pkg::ST_STUCK
                                                                : co2rc_pkg::ST_STALE;
              end
            end
          end else begin
            if (bytes_received == 4'd0) begin
              if (item.rx_byte != co2rc_pkg::HEADER_START) begin
                header_good_next = 1'b0;
              end
            end else begin
              running_sum_next = running_sum + item.rx_byte;
              if (bytes_received == 4'd1 && item.rx_byte != co2rc_pkg::HEADER_CMD) begin
                header_good_next = 1'b0;
              end
              if (bytes_received == 4'd2) begin
                level_high_byte_next = item.rx_byte;
              end
              if (bytes_received == 4'd3) begin
                level_low_byte_next = item.rx_byte;
              end
            end
            bytes_received_next = bytes_received + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase

    result.repeat_count = same_streak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_received  <= 4'd0;
      header_good     <= 1'b1;
      running_sum     <= 8'd0;
      level_high_byte <= 8'd0;
      level_low_byte  <= 8'd0;
      previous_level  <= 16'd0;
      same_streak     <= 8'd0;
    end else if (step) begin
      bytes_received  <= bytes_received_next;
      header_good     <= header_good_next;
      running_sum     <= running_sum_next;
      level_high_byte <= level_high_byte_next;
      level_low_byte  <= level_low_byte_next;
      previous_level  <= previous_level_next;
      same_streak     <= same_streak_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_received <= FullPos)
    else $error("frame byte count beyond frame length");

  a_zero_keeps_streak: assert property (@(posedge clk) disable iff (rst)
    step && result_valid && result.status == co2rc_pkg::ST_ZERO |=> $stable(same_streak))
    else $error("zero reading changed the streak");

  a_closed_after_result: assert property (@(posedge clk) disable iff (rst)
    step && result_valid |=> bytes_received == FullPos)
    else $error("frame not closed after a result");

endmodule

`default_nettype wire

// ===== src/co2rc_out_stage.sv =====
// ----------------------------------------------------------------------------
// CO2 reply checker result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module co2rc_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire co2rc_pkg::out_item_t  load_item,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output co2rc_pkg::out_item_t       out_item,
  output logic                       blocked
);

  assign blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_co2_sensor_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CO2 sensor reply checker testbench
// Feeds reply bytes, starts and timeouts through the item channel and checks
// each reported reading against a frame decoder kept alongside the block.
// Directed frames come first, then randomised phases with varied thresholds,
// a long output hold-off and a run of identical readings.
// ----------------------------------------------------------------------------

module tb_co2_sensor_reply_checker;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_PCT = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STREAK_FRAMES = 15;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  co2rc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  co2rc_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = co2rc_pkg::REG_STALE_REPEAT_CYCLES;
  logic [15:0] cfg_data = '0;

  co2_sensor_reply_checker DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  co2rc_pkg::in_item_t byte_queue[$];
  co2rc_pkg::out_item_t reading_queue[$];
  int items_queued = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic squeeze_on = 1'b0;
  logic squeeze_done = 1'b0;
  logic quiet_on = 1'b0;
  logic [15:0] recent_level = 16'd420;

  // decoder state and thresholds
  logic [7:0] cfg_stale = co2rc_pkg::STALE_RESET;
  logic [15:0] cfg_susp = co2rc_pkg::SUSPICIOUS_RESET;
  logic [3:0] frame_pos = '0;
  logic hdr_ok = 1'b1;
  logic [7:0] sum_acc = '0;
  logic [7:0] lvl_hi = '0;
  logic [7:0] lvl_lo = '0;
  logic [15:0] last_level = '0;
  logic [7:0] streak = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic decode_reply(input co2rc_pkg::in_item_t it);
    co2rc_pkg::out_item_t res;
    logic [15:0] level;
    logic [7:0] want_sum;
    if (it.action == co2rc_pkg::ACT_START) begin
      frame_pos = '0;
      hdr_ok = 1'b1;
      sum_acc = '0;
      lvl_hi = '0;
      lvl_lo = '0;
    end else if (it.action == co2rc_pkg::ACT_TIMEOUT) begin
      if (frame_pos < 4'(co2rc_pkg::FrameLen)) begin
        frame_pos = 4'(co2rc_pkg::FrameLen);
        res.status = co2rc_pkg::ST_NO_REPLY;
        res.ppm = '0;
        res.repeat_count = streak;
        reading_queue.push_back(res);
      end
    end else if (it.action == co2rc_pkg::ACT_BYTE && frame_pos < 4'(co2rc_pkg::FrameLen)) begin
      if (frame_pos == 4'(co2rc_pkg::FrameLen - 1)) begin
        frame_pos = 4'(co2rc_pkg::FrameLen);
        want_sum = 8'd0 - sum_acc;
        level = {lvl_hi, lvl_lo};
        res.ppm = '0;
        if (!hdr_ok) begin
          res.status = co2rc_pkg::ST_BAD_FRAME;
        end else if (want_sum != it.rx_byte) begin
          res.status = co2rc_pkg::ST_BAD_SUM;
        end else if (level == 16'd0) begin
          res.status = co2rc_pkg::ST_ZERO;
        end else begin
          if (level == last_level) begin
            if (streak != 8'hFF) streak = streak + 8'd1;
          end else begin
            streak = '0;
          end
          last_level = level;
          res.ppm = level;
          if ({1'b0, streak} + 9'd1 >= {1'b0, cfg_stale}) begin
            res.status = (level >= cfg_susp) ? co2rc_pkg::ST_STUCK : co2rc_pkg::ST_STALE;
          end else begin
            res.status = co2rc_pkg::ST_OK;
          end
        end
        res.repeat_count = streak;
        reading_queue.push_back(res);
      end else begin
        if (frame_pos == 4'd0) begin
          if (it.rx_byte != co2rc_pkg::HEADER_START) hdr_ok = 1'b0;
        end else begin
          sum_acc = sum_acc + it.rx_byte;
          if (frame_pos == 4'd1 && it.rx_byte != co2rc_pkg::HEADER_CMD) hdr_ok = 1'b0;
          if (frame_pos == 4'd2) lvl_hi = it.rx_byte;
          if (frame_pos == 4'd3) lvl_lo = it.rx_byte;
        end
        frame_pos = frame_pos + 4'd1;
      end
    end
  endtask

  // driver: hold while stalled, otherwise advance to the next pending item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) decode_reply(in_item);
      if (byte_queue.size() != 0 && (quiet_on || $urandom_range(99) >= IDLE_PCT)) begin
        in_item <= byte_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    co2rc_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reading_queue.size() == 0) begin
          $error("unexpected result: status %0d ppm %0d repeat_count %0d",
                 out_item.status, out_item.ppm, out_item.repeat_count);
          error_count++;
        end else begin
          want = reading_queue.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            error_count++;
          end
          if (out_item.ppm !== want.ppm) begin
            $error("ppm: expected %0d, actual %0d", want.ppm, out_item.ppm);
            error_count++;
          end
          if (out_item.repeat_count !== want.repeat_count) begin
            $error("repeat_count: expected %0d, actual %0d",
                   want.repeat_count, out_item.repeat_count);
            error_count++;
          end
        end
      end
      if (squeeze_on && !squeeze_done) begin
        squeeze_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [7:0] data);
    co2rc_pkg::in_item_t it;
    it.action = act;
    it.rx_byte = data;
    byte_queue.push_back(it);
    items_queued++;
  endtask

  task automatic push_frame(input logic [15:0] level, input bit bad_hdr, input bit bad_sum);
    logic [7:0] frame [0:8];
    logic [7:0] acc;
    int k;
    frame[0] = co2rc_pkg::HEADER_START;
    frame[1] = co2rc_pkg::HEADER_CMD;
    frame[2] = level[15:8];
    frame[3] = level[7:0];
    for (k = 4; k < 8; k++) frame[k] = 8'($urandom);
    if (bad_hdr) begin
      k = $urandom_range(2);
      if (k != 1) frame[0] = co2rc_pkg::HEADER_START ^ 8'($urandom_range(1, 255));
      if (k != 0) frame[1] = co2rc_pkg::HEADER_CMD ^ 8'($urandom_range(1, 255));
    end
    acc = '0;
    for (k = 1; k < 8; k++) acc = acc + frame[k];
    frame[8] = 8'd0 - acc;
    if (bad_sum) frame[8] = frame[8] ^ 8'($urandom_range(1, 255));
    push_item(co2rc_pkg::ACT_START, 8'($urandom));
    for (k = 0; k < 9; k++) push_item(co2rc_pkg::ACT_BYTE, frame[k]);
  endtask

  function automatic logic [15:0] pick_level();
    logic [15:0] lvl;
    int r;
    r = $urandom_range(99);
    if (r < 8) lvl = 16'd0;
    else if (r < 50) lvl = recent_level;
    else if (r < 62) lvl = cfg_susp + 16'($urandom_range(2)) - 16'd1;
    else if (r < 70) lvl = ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1;
    else lvl = 16'($urandom);
    if (lvl != 16'd0) recent_level = lvl;
    return lvl;
  endfunction

  task automatic push_traffic(input int n);
    int target;
    int r;
    int k;
    int j;
    target = items_queued + n;
    while (items_queued < target) begin
      r = $urandom_range(99);
      if (r < 58) begin
        push_frame(pick_level(), 1'b0, 1'b0);
      end else if (r < 66) begin
        push_frame(pick_level(), 1'b1, 1'b0);
      end else if (r < 74) begin
        push_frame(pick_level(), 1'b0, 1'b1);
      end else if (r < 78) begin
        push_frame(pick_level(), 1'b1, 1'b1);
      end else if (r < 88) begin
        push_item(co2rc_pkg::ACT_START, 8'($urandom));
        k = $urandom_range(8);
        for (j = 0; j < k; j++) begin
          if (j == 0 && $urandom_range(3) != 0)
            push_item(co2rc_pkg::ACT_BYTE, co2rc_pkg::HEADER_START);
          else if (j == 1 && $urandom_range(3) != 0)
            push_item(co2rc_pkg::ACT_BYTE, co2rc_pkg::HEADER_CMD);
          else push_item(co2rc_pkg::ACT_BYTE, 8'($urandom));
        end
        if ($urandom_range(3) != 0) push_item(co2rc_pkg::ACT_TIMEOUT, 8'($urandom));
      end else if (r < 94) begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) push_item(2'($urandom), 8'($urandom));
      end else begin
        push_frame(pick_level(), 1'b0, 1'b0);
        k = $urandom_range(1, 3);
        for (j = 0; j < k; j++)
          push_item(($urandom_range(1) != 0) ? co2rc_pkg::ACT_BYTE : co2rc_pkg::ACT_TIMEOUT,
                    8'($urandom));
      end
    end
  endtask

  // identical readings across the stale threshold, with harmless faults mixed in
  task automatic push_streak_run(input logic [15:0] level, input int count);
    int good;
    int r;
    good = 0;
    while (good < count) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_frame(level, 1'b0, 1'b1);
      end else if (r < 12) begin
        push_frame(16'd0, 1'b0, 1'b0);
      end else begin
        push_frame(level, 1'b0, 1'b0);
        good++;
      end
    end
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid || reading_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == co2rc_pkg::REG_STALE_REPEAT_CYCLES) cfg_stale = data[7:0];
    else cfg_susp = data;
  endtask

  task automatic set_regs(input logic [7:0] stale, input logic [15:0] susp);
    write_reg(co2rc_pkg::REG_STALE_REPEAT_CYCLES, {8'($urandom), stale});
    write_reg(co2rc_pkg::REG_SUSPICIOUS_LEVEL, susp);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_item(co2rc_pkg::ACT_TIMEOUT, 8'h00);
    push_item(co2rc_pkg::ACT_TIMEOUT, 8'hFF);
    push_item(ACT_UNUSED, 8'hFF);
    push_frame(16'hFFFF, 1'b0, 1'b0);
    push_item(co2rc_pkg::ACT_BYTE, 8'h00);
    push_frame(16'd0, 1'b0, 1'b0);
    push_item(co2rc_pkg::ACT_START, 8'h00);
    push_item(co2rc_pkg::ACT_BYTE, co2rc_pkg::HEADER_START);
    push_item(co2rc_pkg::ACT_TIMEOUT, 8'h00);
    drain();

    push_traffic(150);
    drain();
    set_regs(8'd1, 16'd0);
    push_traffic(170);
    drain();
    set_regs(8'd255, 16'hFFFF);
    push_traffic(170);
    drain();
    set_regs(8'd0, 16'($urandom));
    push_traffic(170);
    drain();
    set_regs(8'd2, 16'd3000);
    push_traffic(200);
    squeeze_on <= 1'b1;
    drain();
    squeeze_on <= 1'b0;
    quiet_on <= 1'b1;
    set_regs(8'($urandom_range(1, 6)), 16'($urandom_range(0, 8000)));
    push_traffic(170);
    drain();
    quiet_on <= 1'b0;
    set_regs(8'd8, 16'($urandom));
    push_streak_run(16'($urandom_range(1, 65535)), STREAK_FRAMES);
    drain();
    set_regs(co2rc_pkg::STALE_RESET, co2rc_pkg::SUSPICIOUS_RESET);
    push_traffic(150);
    drain();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
